// ===== sv/oprm_pkg.sv =====
// shared types, constants and saturation helpers for the phase response map
`default_nettype none
package oprm_pkg;
   localparam int KIND_W   = 2;
   localparam int TGT_W    = 3;
   localparam int BIN_W    = 10;
   localparam int PHASE_W  = 32;
   localparam int TIME_W   = 40;
   localparam int TOL_W    = 16;
   localparam int MASK_W   = 8;
   localparam int COUNT_W  = 4;
   localparam int DIV_CW   = 6;
   localparam logic [DIV_CW-1:0] DIV_LAST = 6'd63;
   localparam logic signed [33:0] ONE_Q24 = 34'sd16777216;
   localparam logic [TIME_W-1:0] TIME_MAX = 40'hFFFFFFFFFF;
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd17;

   typedef enum logic [KIND_W-1:0] {
      KIND_FIRST  = 2'd0,
      KIND_SECOND = 2'd1,
      KIND_CELL   = 2'd2,
      KIND_STEP   = 2'd3
   } oprm_kind_type;

   typedef struct packed {
      logic do_load;
      logic first_cell;
      logic next_cell;
      logic mul_lo;
      logic mul_hi;
      logic t_store;
      logic mark;
      logic rd_fired;
      logic div_start;
      logic div_step;
      logic adv;
      logic idx_mul;
      logic lookup;
      logic upd_fired;
      logic upd_free;
      logic publish;
   } oprm_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              last_cell;
      logic              cur_fired;
      logic              div_last;
      logic              out_free;
   } oprm_status_type;

   function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
      return {{2{v[31]}}, v};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh07FFFFFFF)       r = 32'sh7FFFFFFF;
      else if (v < -34'sh080000000) r = 32'sh80000000;
      else                          r = v[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== sv/oprm_intf.sv =====
// channel interfaces for request items, result items and the csr write
`default_nettype none
interface oprm_req_if import oprm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic [TGT_W-1:0]          target_index;
   logic [BIN_W-1:0]          entry_index;
   logic signed [PHASE_W-1:0] entry_value;
   logic [TIME_W-1:0]         period_value;
   modport source (output valid, kind, target_index, entry_index, entry_value,
                   period_value, input ready);
   modport sink (input valid, kind, target_index, entry_index, entry_value,
                 period_value, output ready);
endinterface

interface oprm_rsp_if import oprm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [MASK_W-1:0]         fired_mask;
   logic [COUNT_W-1:0]        fired_count;
   logic [TIME_W-1:0]         fire_time;
   logic signed [PHASE_W-1:0] phase_difference;
   logic                      difference_valid;
   logic                      index_clamped;
   modport source (output valid, fired_mask, fired_count, fire_time, phase_difference,
                   difference_valid, index_clamped, input ready);
   modport sink (input valid, fired_mask, fired_count, fire_time, phase_difference,
                 difference_valid, index_clamped, output ready);
endinterface

interface oprm_csr_if import oprm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [TOL_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== sv/oscillator_phase_response_map.sv =====
// Event map for pulse-coupled oscillators. Kinds 0 and 1 write one entry of the first- or
// second-order response table of a group, and kind 2 sets a cell's phase and period; these
// give no result. Kind 3 runs one firing event and gives one result item: a decode step,
// then per cell the time to fire is found on the shared multiplier (low product, high
// product, sum), then the fired cells are marked, then each fired cell is updated from the
// tables while each waiting cell runs the 64-step bit-serial divider for time/period, the
// phase advance, the table index and the lookup, and last the result is published once
// the result slot is free. Items are taken one at a time; a finished result waits in the
// output register while the next item is accepted. The tables are not cleared by reset.
`default_nettype none
module oscillator_phase_response_map import oprm_pkg::*; #(
   parameter int CELLS     = 2,
   parameter int TABLE_LEN = 1024
) (
   input  wire logic    clock,
   input  wire logic    reset,
   oprm_req_if.sink     req_bus,
   oprm_rsp_if.source   rsp_bus,
   oprm_csr_if.sink     csr_bus
);
   oprm_cmd_type    cmd;
   oprm_status_type status;
   logic            req_ready;

   assign req_bus.ready = req_ready;
   assign csr_bus.ready = 1'b1;

   oprm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   oprm_datapath #(
      .CELLS     (CELLS),
      .TABLE_LEN (TABLE_LEN)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_accept           (req_bus.valid && req_ready),
      .req_kind             (req_bus.kind),
      .req_target_index     (req_bus.target_index),
      .req_entry_index      (req_bus.entry_index),
      .req_entry_value      (req_bus.entry_value),
      .req_period_value     (req_bus.period_value),
      .csr_we               (csr_bus.valid),
      .csr_data             (csr_bus.data),
      .rsp_valid            (rsp_bus.valid),
      .rsp_ready            (rsp_bus.ready),
      .rsp_fired_mask       (rsp_bus.fired_mask),
      .rsp_fired_count      (rsp_bus.fired_count),
      .rsp_fire_time        (rsp_bus.fire_time),
      .rsp_phase_difference (rsp_bus.phase_difference),
      .rsp_difference_valid (rsp_bus.difference_valid),
      .rsp_index_clamped    (rsp_bus.index_clamped)
   );
endmodule
`default_nettype wire

// ===== sv/oprm_datapath.sv =====
// cell state, response tables, multiplier, divider and result register
`default_nettype none
module oprm_datapath import oprm_pkg::*; #(
   parameter int CELLS     = 2,
   parameter int TABLE_LEN = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire oprm_cmd_type              cmd,
   output oprm_status_type                status,
   input  wire logic                      req_accept,
   input  wire logic [KIND_W-1:0]         req_kind,
   input  wire logic [TGT_W-1:0]          req_target_index,
   input  wire logic [BIN_W-1:0]          req_entry_index,
   input  wire logic signed [PHASE_W-1:0] req_entry_value,
   input  wire logic [TIME_W-1:0]         req_period_value,
   input  wire logic                      csr_we,
   input  wire logic [TOL_W-1:0]          csr_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [MASK_W-1:0]              rsp_fired_mask,
   output logic [COUNT_W-1:0]             rsp_fired_count,
   output logic [TIME_W-1:0]              rsp_fire_time,
   output logic signed [PHASE_W-1:0]      rsp_phase_difference,
   output logic                           rsp_difference_valid,
   output logic                           rsp_index_clamped
);
   localparam int CW    = $clog2(CELLS);
   localparam int DEPTH = (CELLS - 1) * TABLE_LEN;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TW    = $clog2(TABLE_LEN);

   // latched item
   logic [KIND_W-1:0]         kind_ff;
   logic [TGT_W-1:0]          tgt_ff;
   logic [BIN_W-1:0]          bin_ff;
   logic signed [PHASE_W-1:0] val_ff;
   logic [TIME_W-1:0]         per_ff;

   logic [TOL_W-1:0]          tol_ff;
   logic signed [PHASE_W-1:0] phase_ff [CELLS];
   logic signed [PHASE_W-1:0] pend_ff  [CELLS];
   logic [TIME_W-1:0]         period_ff[CELLS];
   logic [TIME_W-1:0]         t_ff     [CELLS];
   logic [CW-1:0]             cur_ff;
   logic [TIME_W-1:0]         tmin_ff;
   logic [CELLS-1:0]          fired_ff;
   logic [COUNT_W-1:0]        sim_ff;
   logic signed [PHASE_W-1:0] diff_ff;
   logic                      dvalid_ff;
   logic                      clamped_ff;
   logic [31:0]               lo_ff;
   logic [47:0]               hi_ff;
   logic [39:0]               rem_ff;
   logic [63:0]               dvd_ff;
   logic [31:0]               q_ff;
   logic                      ovf_ff;
   logic [DIV_CW-1:0]         div_cnt_ff;
   logic signed [PHASE_W-1:0] adv_ff;
   logic [47:0]               p_ff;

   logic signed [PHASE_W-1:0] fo_mem [DEPTH];
   logic signed [PHASE_W-1:0] so_mem [DEPTH];
   logic signed [PHASE_W-1:0] fo_rd_ff;
   logic signed [PHASE_W-1:0] so_rd_ff;

   logic                      rsp_valid_ff;
   logic [MASK_W-1:0]         out_mask_ff;
   logic [COUNT_W-1:0]        out_count_ff;
   logic [TIME_W-1:0]         out_time_ff;
   logic signed [PHASE_W-1:0] out_diff_ff;
   logic                      out_dvalid_ff;
   logic                      out_clamp_ff;

   logic signed [PHASE_W-1:0] cur_phase;
   logic signed [PHASE_W-1:0] cur_pend;
   logic [TIME_W-1:0]         cur_period;
   logic signed [33:0]        ttf_diff;
   logic                      ttf_pos;
   logic [23:0]               mul_a;
   logic [55:0]               prod;
   logic [48:0]               tsum;
   logic [TIME_W-1:0]         t_in;
   logic [TIME_W-1:0]         tol40;
   logic [CELLS-1:0]          fired_in;
   logic [COUNT_W-1:0]        sim_in;
   logic [40:0]               rem_sh;
   logic                      ge;
   logic [40:0]               rem_sub;
   logic [31:0]               q_sat;
   logic [23:0]               fl;
   logic [TW-1:0]             idx;
   logic                      idx_clamp;
   logic [31:0]               look_addr32;
   logic [31:0]               fired_addr32;
   logic [31:0]               wr_addr32;
   logic                      load_tbl_ok;
   logic                      load_cell_ok;
   logic [AW-1:0]             rd_addr;
   logic signed [PHASE_W-1:0] acc_fired;

   assign cur_phase  = phase_ff[cur_ff];
   assign cur_pend   = pend_ff[cur_ff];
   assign cur_period = period_ff[cur_ff];

   // time to fire: period*(1-phase) as hi*d + (lo*d)>>24
   assign ttf_diff = ONE_Q24 - sx34(cur_phase);
   assign ttf_pos  = !ttf_diff[33] && (ttf_diff != 34'sd0);
   assign mul_a    = cmd.mul_hi ? {8'd0, cur_period[39:24]} : cur_period[23:0];
   assign prod     = 56'(mul_a) * 56'(ttf_diff[31:0]);
   assign tsum     = {1'b0, hi_ff} + 49'(lo_ff);
   assign t_in     = !ttf_pos ? '0 :
                     (tsum > 49'(TIME_MAX)) ? TIME_MAX : tsum[TIME_W-1:0];

   assign tol40 = (tol_ff == '0) ? 40'd1 : 40'(tol_ff);
   always_comb begin
      fired_in = '0;
      sim_in   = '0;
      for (int n = 0; n < CELLS; n++) begin
         fired_in[n] = (t_ff[n] - tmin_ff) < tol40;
         sim_in      = sim_in + COUNT_W'(fired_in[n]);
      end
   end

   // restoring division, one quotient bit per cycle
   assign rem_sh  = {rem_ff, dvd_ff[63]};
   assign ge      = rem_sh >= {1'b0, cur_period};
   assign rem_sub = rem_sh - {1'b0, cur_period};
   assign q_sat   = (ovf_ff || q_ff[31]) ? 32'h7FFFFFFF : q_ff;

   // floor(adv*TABLE_LEN / 2^24) with clamping
   assign fl        = p_ff[47:24];
   assign idx_clamp = p_ff[47] || (fl >= 24'(TABLE_LEN));
   assign idx       = p_ff[47] ? '0 :
                      (fl >= 24'(TABLE_LEN)) ? TW'(TABLE_LEN - 1) : fl[TW-1:0];

   assign look_addr32  = 32'(sim_ff - 4'd1) * 32'(TABLE_LEN) + 32'(idx);
   assign fired_addr32 = (sim_ff > 4'd1) ? 32'(sim_ff - 4'd2) * 32'(TABLE_LEN) : 32'd0;
   assign rd_addr      = cmd.lookup ? AW'(look_addr32) : AW'(fired_addr32);
   assign wr_addr32    = 32'(tgt_ff) * 32'(TABLE_LEN) + 32'(bin_ff);
   assign load_tbl_ok  = (32'(tgt_ff) < 32'(CELLS - 1)) && (32'(bin_ff) < 32'(TABLE_LEN));
   assign load_cell_ok = 32'(tgt_ff) < 32'(CELLS);
   assign acc_fired    = sat32(sx34(cur_pend) + sx34(so_rd_ff));

   always_ff @(posedge clock) begin
      if (cmd.do_load && load_tbl_ok && kind_ff == KIND_FIRST) begin
         fo_mem[AW'(wr_addr32)] <= val_ff;
      end
      if (cmd.lookup || cmd.rd_fired) begin
         fo_rd_ff <= fo_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_load && load_tbl_ok && kind_ff == KIND_SECOND) begin
         so_mem[AW'(wr_addr32)] <= val_ff;
      end
      if (cmd.lookup || cmd.rd_fired) begin
         so_rd_ff <= so_mem[rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff <= req_kind;
         tgt_ff  <= req_target_index;
         bin_ff  <= req_entry_index;
         val_ff  <= req_entry_value;
         per_ff  <= req_period_value;
      end
      if (cmd.do_load && load_cell_ok && kind_ff == KIND_CELL) begin
         period_ff[CW'(tgt_ff)] <= per_ff;
      end
      if (cmd.mul_lo) lo_ff <= prod[55:24];
      if (cmd.mul_hi) hi_ff <= prod[47:0];
      if (cmd.t_store) begin
         t_ff[cur_ff] <= t_in;
         if (cur_ff == '0 || t_in < tmin_ff) tmin_ff <= t_in;
      end
      if (cmd.mark) begin
         fired_ff  <= fired_in;
         sim_ff    <= sim_in;
         dvalid_ff <= fired_in[1];
         diff_ff   <= fired_in[1] ? sat32(sx34(phase_ff[1]) - sx34(phase_ff[0])) : '0;
      end
      if (cmd.div_start) begin
         rem_ff     <= '0;
         dvd_ff     <= {tmin_ff, 24'd0};
         q_ff       <= '0;
         ovf_ff     <= 1'b0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= ge ? rem_sub[39:0] : rem_sh[39:0];
         dvd_ff     <= {dvd_ff[62:0], 1'b0};
         q_ff       <= {q_ff[30:0], ge};
         ovf_ff     <= ovf_ff | q_ff[31];
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
      if (cmd.adv) adv_ff <= sat32(sx34(cur_phase) + sx34($signed(q_sat)));
      if (cmd.idx_mul) p_ff <= {{16{adv_ff[31]}}, adv_ff} * 48'(TABLE_LEN);
      if (cmd.publish) begin
         out_mask_ff   <= MASK_W'(fired_ff);
         out_count_ff  <= sim_ff;
         out_time_ff   <= tmin_ff;
         out_diff_ff   <= diff_ff;
         out_dvalid_ff <= dvalid_ff;
         out_clamp_ff  <= clamped_ff;
      end
   end

   // control and reset-cleared state
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= TOL_RESET;
         cur_ff       <= '0;
         clamped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < CELLS; n++) begin
            phase_ff[n] <= '0;
            pend_ff[n]  <= '0;
         end
      end else begin
         if (csr_we) tol_ff <= csr_data;
         if (cmd.first_cell) cur_ff <= '0;
         else if (cmd.next_cell) cur_ff <= cur_ff + 1'b1;
         if (cmd.mark) clamped_ff <= 1'b0;
         else if (cmd.lookup && idx_clamp) clamped_ff <= 1'b1;
         if (cmd.do_load && load_cell_ok && kind_ff == KIND_CELL) begin
            phase_ff[CW'(tgt_ff)] <= val_ff;
            pend_ff[CW'(tgt_ff)]  <= '0;
         end
         if (cmd.upd_fired) begin
            if (sim_ff > 4'd1) begin
               phase_ff[cur_ff] <= sat32(-sx34(acc_fired) - sx34(fo_rd_ff));
            end else begin
               phase_ff[cur_ff] <= sat32(-sx34(cur_pend));
            end
            pend_ff[cur_ff] <= '0;
         end
         if (cmd.upd_free) begin
            pend_ff[cur_ff]  <= sat32(sx34(cur_pend) + sx34(so_rd_ff));
            phase_ff[cur_ff] <= sat32(sx34(adv_ff) - sx34(fo_rd_ff));
         end
         if (cmd.publish) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign status.kind      = kind_ff;
   assign status.last_cell = cur_ff == CW'(CELLS - 1);
   assign status.cur_fired = fired_ff[cur_ff];
   assign status.div_last  = div_cnt_ff == DIV_LAST;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_fired_mask       = out_mask_ff;
   assign rsp_fired_count      = out_count_ff;
   assign rsp_fire_time        = out_time_ff;
   assign rsp_phase_difference = out_diff_ff;
   assign rsp_difference_valid = out_dvalid_ff;
   assign rsp_index_clamped    = out_clamp_ff;
endmodule
`default_nettype wire

// ===== sv/oprm_ctrl.sv =====
// sequencer that walks the cells through an event
`default_nettype none
module oprm_ctrl import oprm_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire oprm_status_type status,
   output oprm_cmd_type         cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_TTF_LO, S_TTF_HI, S_TTF_SUM, S_MARK, S_CELL,
      S_FIRED, S_DIV, S_ADV, S_IDX, S_LOOK, S_FREE, S_PUB
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (status.kind == KIND_STEP) begin
               cmd.first_cell = 1'b1;
               state_in       = S_TTF_LO;
            end else begin
               cmd.do_load = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_TTF_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_TTF_HI;
         end
         S_TTF_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_TTF_SUM;
         end
         S_TTF_SUM: begin
            cmd.t_store = 1'b1;
            if (status.last_cell) begin
               state_in = S_MARK;
            end else begin
               cmd.next_cell = 1'b1;
               state_in      = S_TTF_LO;
            end
         end
         S_MARK: begin
            cmd.mark       = 1'b1;
            cmd.first_cell = 1'b1;
            state_in       = S_CELL;
         end
         S_CELL: begin
            if (status.cur_fired) begin
               cmd.rd_fired = 1'b1;
               state_in     = S_FIRED;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_FIRED: begin
            cmd.upd_fired = 1'b1;
            if (status.last_cell) begin
               state_in = S_PUB;
            end else begin
               cmd.next_cell = 1'b1;
               state_in      = S_CELL;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_ADV;
         end
         S_ADV: begin
            cmd.adv  = 1'b1;
            state_in = S_IDX;
         end
         S_IDX: begin
            cmd.idx_mul = 1'b1;
            state_in    = S_LOOK;
         end
         S_LOOK: begin
            cmd.lookup = 1'b1;
            state_in   = S_FREE;
         end
         S_FREE: begin
            cmd.upd_free = 1'b1;
            if (status.last_cell) begin
               state_in = S_PUB;
            end else begin
               cmd.next_cell = 1'b1;
               state_in      = S_CELL;
            end
         end
         S_PUB: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> status.out_free) else $error("result published over a full slot");
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_DECODE) else $error("item not decoded");
   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && !status.div_last) |=> state_ff == S_DIV)
      else $error("division left early");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/oprm_checker.sv =====
// checker for the phase response map: predicts each step result and compares it
`default_nettype none
module oprm_checker import oprm_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   oprm_req_if.sink  req_mon,
   oprm_rsp_if.sink  rsp_mon,
   oprm_csr_if.sink  csr_mon,
   output int        fail_count,
   output int        pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [MASK_W-1:0]         fired_mask;
      logic [COUNT_W-1:0]        fired_count;
      logic [TIME_W-1:0]         fire_time;
      logic signed [PHASE_W-1:0] phase_difference;
      logic                      difference_valid;
      logic                      index_clamped;
   } event_result_type;

   localparam longint Q24 = 64'sd16777216;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   logic signed [31:0] first_tab [1024];
   logic signed [31:0] second_tab [1024];
   logic signed [31:0] phase_of [2];
   logic [39:0]        period_of [2];
   logic signed [31:0] carry_of [2];
   logic [15:0]        window;
   event_result_type   expected_events [$];

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > S32_MAX) return 32'sh7FFFFFFF;
      if (v < S32_MIN) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic [39:0] fire_delay(input logic [39:0] per,
                                              input logic signed [31:0] ph);
      longint d;
      logic [63:0] t;
      d = Q24 - longint'(ph);
      if (d <= 0) return '0;
      t = 64'(per[39:24]) * 64'(d) + ((64'(per[23:0]) * 64'(d)) >> 24);
      if (t > 64'hFFFFFFFFFF) return 40'hFFFFFFFFFF;
      return t[39:0];
   endfunction

   task automatic run_event();
      logic [39:0] t [2];
      logic [39:0] tmin, tol;
      logic [63:0] q;
      event_result_type r;
      longint p, ix, ph;
      logic signed [31:0] adv;
      int sim, minc, idx;
      sim = 0;
      minc = 0;
      r = '0;
      for (int n = 0; n < 2; n++) begin
         t[n] = fire_delay(period_of[n], phase_of[n]);
         if (t[n] < t[minc]) minc = n;
      end
      tmin = t[minc];
      tol = (window == 0) ? 40'd1 : 40'(window);
      for (int n = 0; n < 2; n++) begin
         if (t[n] - tmin < tol) begin
            r.fired_mask[n] = 1'b1;
            sim++;
         end
      end
      r.difference_valid = r.fired_mask[1];
      if (r.difference_valid)
         r.phase_difference = clip32(longint'(phase_of[1]) - longint'(phase_of[0]));
      for (int n = 0; n < 2; n++) begin
         if (r.fired_mask[n]) begin
            ph = -longint'(carry_of[n]);
            // both cells together: group zero row, bin zero
            if (sim > 1)
               ph = -longint'(clip32(longint'(carry_of[n]) + longint'(second_tab[0])))
                    - longint'(first_tab[0]);
            phase_of[n] = clip32(ph);
            carry_of[n] = '0;
         end else begin
            if (period_of[n] == 0) q = 64'h7FFFFFFF;
            else q = {tmin, 24'd0} / 64'(period_of[n]);
            if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
            adv = clip32(longint'(phase_of[n]) + longint'(q));
            p = longint'(adv) * 1024;
            if (p >= 0) ix = p / Q24;
            else ix = -((-p + Q24 - 1) / Q24);
            if (ix < 0) begin
               idx = 0;
               r.index_clamped = 1'b1;
            end else if (ix >= 1024) begin
               idx = 1023;
               r.index_clamped = 1'b1;
            end else idx = int'(ix);
            carry_of[n] = clip32(longint'(carry_of[n]) + longint'(second_tab[idx]));
            phase_of[n] = clip32(longint'(adv) - longint'(first_tab[idx]));
         end
      end
      r.fired_count = COUNT_W'(sim);
      r.fire_time = tmin;
      expected_events.push_back(r);
   endtask

   always @(posedge clock) begin
      event_result_type e;
      if (reset) begin
         for (int i = 0; i < 1024; i++) begin
            first_tab[i] <= '0;
            second_tab[i] <= '0;
         end
         for (int n = 0; n < 2; n++) begin
            phase_of[n] <= '0;
            period_of[n] <= '0;
            carry_of[n] <= '0;
         end
         window <= TOL_RESET;
         fail_count <= 0;
         expected_events.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) window = csr_mon.data;
         if (req_mon.valid && req_mon.ready) begin
            case (oprm_kind_type'(req_mon.kind))
               KIND_FIRST: begin
                  if (req_mon.target_index == 0) first_tab[req_mon.entry_index] = req_mon.entry_value;
               end
               KIND_SECOND: begin
                  if (req_mon.target_index == 0) second_tab[req_mon.entry_index] = req_mon.entry_value;
               end
               KIND_CELL: begin
                  if (req_mon.target_index < 2) begin
                     phase_of[req_mon.target_index[0]] = req_mon.entry_value;
                     period_of[req_mon.target_index[0]] = req_mon.period_value;
                     carry_of[req_mon.target_index[0]] = '0;
                  end
               end
               default: run_event();
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_events.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) $display("unexpected result item at %0t", $realtime);
            end else begin
               e = expected_events.pop_front();
               if (e.fired_mask !== rsp_mon.fired_mask
                   || e.fired_count !== rsp_mon.fired_count
                   || e.fire_time !== rsp_mon.fire_time
                   || e.phase_difference !== rsp_mon.phase_difference
                   || e.difference_valid !== rsp_mon.difference_valid
                   || e.index_clamped !== rsp_mon.index_clamped) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10)
                     $display("mismatch: expected mask %h cnt %0d time %h diff %h dv %b cl %b, got mask %h cnt %0d time %h diff %h dv %b cl %b",
                        e.fired_mask, e.fired_count, e.fire_time, e.phase_difference,
                        e.difference_valid, e.index_clamped, rsp_mon.fired_mask,
                        rsp_mon.fired_count, rsp_mon.fire_time, rsp_mon.phase_difference,
                        rsp_mon.difference_valid, rsp_mon.index_clamped);
               end
            end
         end
      end
   end

   assign pending_count = expected_events.size();
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// top of the testbench: clock, reset, stimulus and the verdict
`default_nettype none
module testbench;
   import oprm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   idle_pct = 14;

   oprm_req_if req_bus ();
   oprm_rsp_if rsp_bus ();
   oprm_csr_if csr_bus ();

   oscillator_phase_response_map uut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   oprm_checker checker_i (
      .clock(clock), .reset(reset),
      .req_mon(req_bus.sink), .rsp_mon(rsp_bus.sink), .csr_mon(csr_bus.sink),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always #10 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.kind = '0;
      req_bus.target_index = '0;
      req_bus.entry_index = '0;
      req_bus.entry_value = '0;
      req_bus.period_value = '0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
   end

   // result side stalls at random
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
   end

   // valid stays high after an accept until the next item or an idle cycle replaces it
   task automatic send_item(input oprm_kind_type k, input logic [2:0] tgt,
                            input logic [9:0] bin, input logic [31:0] val,
                            input logic [39:0] per);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind <= k;
      req_bus.target_index <= tgt;
      req_bus.entry_index <= bin;
      req_bus.entry_value <= val;
      req_bus.period_value <= per;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic write_window(input logic [15:0] w);
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= w;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [39:0] rand_period();
      case ($urandom_range(3))
         0: return 40'h1000000 + 40'($urandom_range(16'hFFFF));
         1: return {8'($urandom), $urandom};
         2: return 40'($urandom_range(24'hFFFFFF)) + 40'h800000;
         default: return {$urandom_range(7), 24'($urandom)} + 40'h1000000;
      endcase
   endfunction

   function automatic logic [31:0] rand_phase();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($urandom_range(24'hFFFFFF));
         default: return 32'($urandom_range(32'h1FFFFFF)) - 32'h800000;
      endcase
   endfunction

   task automatic fill_tables(input bit zero);
      for (int i = 0; i < 1024; i++) begin
         send_item(KIND_FIRST, 3'd0, 10'(i), zero ? 32'd0 : 32'($urandom_range(20'hFFFFF)), '0);
         send_item(KIND_SECOND, 3'd0, 10'(i), zero ? 32'd0 : $urandom, '0);
      end
   endtask

   initial begin
      logic [15:0] windows [5];
      int events;
      windows = '{16'd0, 16'd65535, 16'd1, 16'($urandom), 16'd17};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tables written fully so every later read hits a written entry
      fill_tables(1'b0);

      // directed: ignored loads, extremes of fields, periods set before any step
      send_item(KIND_FIRST, 3'd7, 10'd1023, 32'h7FFFFFFF, 40'hFFFFFFFFFF);
      send_item(KIND_SECOND, 3'd1, 10'd0, 32'h80000000, '0);
      send_item(KIND_CELL, 3'd5, 10'd1023, 32'h12345678, 40'h1);
      send_item(KIND_CELL, 3'd0, 10'd0, 32'h0, 40'h1000000);
      send_item(KIND_CELL, 3'd1, 10'd0, 32'h800000, 40'h1000000);
      send_item(KIND_FIRST, 3'd0, 10'd0, 32'h7FFFFFFF, '0);
      send_item(KIND_SECOND, 3'd0, 10'd1023, 32'h80000000, '0);
      send_item(KIND_STEP, '0, '0, '0, '0);
      send_item(KIND_STEP, 3'd7, 10'd1023, 32'hFFFFFFFF, 40'hFFFFFFFFFF);
      // phase past one, long times, a zero period
      send_item(KIND_CELL, 3'd0, '0, 32'h7FFFFFFF, 40'hFFFFFFFFFF);
      send_item(KIND_CELL, 3'd1, '0, 32'h80000000, 40'h0);
      send_item(KIND_STEP, '0, '0, '0, '0);
      send_item(KIND_CELL, 3'd0, '0, 32'h80000000, 40'hFFFFFFFFFF);
      send_item(KIND_CELL, 3'd1, '0, 32'h80000000, 40'hFFFFFFFFFF);
      send_item(KIND_STEP, '0, '0, '0, '0);
      send_item(KIND_CELL, 3'd0, '0, 32'h0, 40'h1);
      send_item(KIND_CELL, 3'd1, '0, 32'h0, 40'hFFFFFFFFFF);
      send_item(KIND_STEP, '0, '0, '0, '0);
      send_item(KIND_STEP, '0, '0, '0, '0);

      for (int ph = 0; ph < 5; ph++) begin
         write_window(windows[ph]);
         idle_pct = (ph == 2) ? 0 : 14;
         events = 0;
         while (events < 100) begin
            case ($urandom_range(9))
               0: begin
                  send_item(KIND_CELL, 3'($urandom_range(7)), 10'($urandom),
                            rand_phase(), rand_period());
               end
               1: send_item(oprm_kind_type'($urandom_range(1)), 3'($urandom_range(7)),
                            10'($urandom), $urandom, {8'($urandom), $urandom});
               2: begin
                  // equal cells so they fire together
                  logic [39:0] pp;
                  logic [31:0] qq;
                  pp = rand_period();
                  qq = rand_phase();
                  send_item(KIND_CELL, 3'd0, '0, qq, pp);
                  send_item(KIND_CELL, 3'd1, '0, qq, pp);
               end
               default: begin
                  send_item(KIND_STEP, 3'($urandom), 10'($urandom), $urandom,
                            {8'($urandom), $urandom});
                  events++;
               end
            endcase
         end
      end
      req_bus.valid <= 1'b0;
      idle_pct = 14;
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #200ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
